/* src/qte_pkg.sv */
// Shared types, widths and the arctangent table for the quaternion to Euler core.
package qte_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int TW = 36;        // Z-Y-X terms, 30 fraction bits
	localparam int CW = 37;        // CORDIC x/y lanes
	localparam int ZW = 33;        // angle accumulator, 28 fraction bits
	localparam int SW = 61;        // square root remainder and root
	localparam int SQ_CELLS = 31;  // one root bit per cell
	localparam int LANES = 3;
	localparam int LANE_ROLL = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW = 2;
	localparam int ANG_MAX = 25736;
	localparam int PITCH_MAX = 12868;

	localparam logic signed [TW-1:0] ONE_Q30 = TW'(64'sd1073741824);
	localparam logic signed [ZW-1:0] PI_Q28 = ZW'(64'sd843314856);

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} lane_t;

	typedef lane_t [LANES-1:0] lanes_t;

	typedef struct packed {
		logic [SW-1:0]        rem;
		logic [SW-1:0]        root;
		logic signed [TW-1:0] t0;
		logic signed [TW-1:0] t1;
		logic signed [TW-1:0] t2;
		logic signed [TW-1:0] t3;
		logic signed [TW-1:0] t4;
	} sq_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:  a = ZW'(64'sd210828714);
			5'd1:  a = ZW'(64'sd124459457);
			5'd2:  a = ZW'(64'sd65760959);
			5'd3:  a = ZW'(64'sd33381290);
			5'd4:  a = ZW'(64'sd16755422);
			5'd5:  a = ZW'(64'sd8385879);
			5'd6:  a = ZW'(64'sd4193963);
			5'd7:  a = ZW'(64'sd2097109);
			5'd8:  a = ZW'(64'sd1048571);
			5'd9:  a = ZW'(64'sd524287);
			5'd10: a = ZW'(64'sd262144);
			5'd11: a = ZW'(64'sd131072);
			5'd12: a = ZW'(64'sd65536);
			5'd13: a = ZW'(64'sd32768);
			5'd14: a = ZW'(64'sd16384);
			5'd15: a = ZW'(64'sd8192);
			5'd16: a = ZW'(64'sd4096);
			5'd17: a = ZW'(64'sd2048);
			5'd18: a = ZW'(64'sd1024);
			5'd19: a = ZW'(64'sd512);
			5'd20: a = ZW'(64'sd256);
			5'd21: a = ZW'(64'sd128);
			5'd22: a = ZW'(64'sd64);
			5'd23: a = ZW'(64'sd32);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* src/qte_sqrt_cell.sv */
// One bit of the restoring integer square root, carrying the terms alongside.
module qte_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [4:0]    step,
	input  logic          in_valid,
	input  qte_pkg::sq_t  in_data,
	output logic          out_valid,
	output qte_pkg::sq_t  out_data
);

	logic [qte_pkg::SW-1:0] bitv;
	logic [qte_pkg::SW-1:0] trial;
	qte_pkg::sq_t           nxt;

	always_comb begin
		bitv = qte_pkg::SW'(1) << {step, 1'b0};
		trial = in_data.root + bitv;
		nxt = in_data;
		if (in_data.rem >= trial) begin
			nxt.rem = in_data.rem - trial;
			nxt.root = (in_data.root >> 1) + bitv;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

/* src/qte_cordic_cell.sv */
// One vectoring CORDIC micro-rotation applied to all three angle lanes.
module qte_cordic_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [4:0]      step,
	input  logic            in_valid,
	input  qte_pkg::lanes_t in_data,
	output logic            out_valid,
	output qte_pkg::lanes_t out_data
);

	qte_pkg::lanes_t        nxt;
	logic signed [qte_pkg::ZW-1:0] ang;

	always_comb begin
		ang = qte_pkg::atan_entry(step);
		for (int l = 0; l < qte_pkg::LANES; l++) begin
			nxt[l] = in_data[l];
			if (!in_data[l].y[qte_pkg::CW-1]) begin
				nxt[l].x = in_data[l].x + (in_data[l].y >>> step);
				nxt[l].y = in_data[l].y - (in_data[l].x >>> step);
				nxt[l].z = in_data[l].z + ang;
			end else begin
				nxt[l].x = in_data[l].x - (in_data[l].y >>> step);
				nxt[l].y = in_data[l].y + (in_data[l].x >>> step);
				nxt[l].z = in_data[l].z - ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

/* src/quaternion_to_euler_core.sv */
// Top level: quaternion in, Z-Y-X Euler angles out, fully pipelined.
//
//  channel   direction  strobe      payload
//  request   in         start/busy  quat_x, quat_y, quat_z, quat_w (Q1.15)
//  result    out        done        roll, yaw (Q3.13, 16b), pitch (Q2.13, 15b)
//
// One request per cycle; busy is always low. The pipeline holds three
// product/term stages, 31 square root cells, one CORDIC setup stage,
// one cell per micro-rotation and a rounding stage.
// Reset clears only the valid bits of the pipeline. The receiver cannot stall:
// each result is shown for exactly one cycle with done high.
module quaternion_to_euler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               done,
	output logic signed [15:0] roll,
	output logic signed [14:0] pitch,
	output logic signed [15:0] yaw
);

	localparam int TW = qte_pkg::TW;
	localparam int CW = qte_pkg::CW;
	localparam int ZW = qte_pkg::ZW;
	localparam int LAT = 36 + qte_pkg::STEPS;

	assign busy = 1'b0;

	// stage 1: products
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, wy_s1, xz_s1, yz_s1, wx_s1;
	logic               v_s1, v_s2, v_s3;

	always_ff @(posedge clk) begin
		xx_s1 <= 32'(quat_x * quat_x);
		yy_s1 <= 32'(quat_y * quat_y);
		zz_s1 <= 32'(quat_z * quat_z);
		xy_s1 <= 32'(quat_x * quat_y);
		wz_s1 <= 32'(quat_w * quat_z);
		wy_s1 <= 32'(quat_w * quat_y);
		xz_s1 <= 32'(quat_x * quat_z);
		yz_s1 <= 32'(quat_y * quat_z);
		wx_s1 <= 32'(quat_w * quat_x);
	end

	// stage 2: terms, pitch term clamped
	logic signed [TW-1:0] t0_s2, t1_s2, t2_s2, t3_s2, t4_s2;
	logic signed [TW-1:0] t2_raw;

	always_comb begin
		t2_raw = (TW'(wy_s1) - TW'(xz_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		t0_s2 <= qte_pkg::ONE_Q30 - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
		t1_s2 <= (TW'(xy_s1) + TW'(wz_s1)) <<< 1;
		t3_s2 <= (TW'(yz_s1) + TW'(wx_s1)) <<< 1;
		t4_s2 <= qte_pkg::ONE_Q30 - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
		if (t2_raw > qte_pkg::ONE_Q30) begin
			t2_s2 <= qte_pkg::ONE_Q30;
		end else if (t2_raw < -qte_pkg::ONE_Q30) begin
			t2_s2 <= -qte_pkg::ONE_Q30;
		end else begin
			t2_s2 <= t2_raw;
		end
	end

	// stage 3: square of the pitch term
	logic signed [30:0]   t2n;
	logic signed [61:0]   t2sq_s3;
	logic signed [TW-1:0] t0_s3, t1_s3, t2_s3, t3_s3, t4_s3;

	assign t2n = t2_s2[30:0];

	always_ff @(posedge clk) begin
		t2sq_s3 <= t2n * t2n;
		t0_s3 <= t0_s2;
		t1_s3 <= t1_s2;
		t2_s3 <= t2_s2;
		t3_s3 <= t3_s2;
		t4_s3 <= t4_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// square root chain: cos(pitch) = sqrt(1 - t2^2)
	qte_pkg::sq_t sq_d [qte_pkg::SQ_CELLS+1];
	logic         sq_v [qte_pkg::SQ_CELLS+1];

	always_comb begin
		sq_v[0] = v_s3;
		sq_d[0].rem = (qte_pkg::SW'(1) << 60) - t2sq_s3[qte_pkg::SW-1:0];
		sq_d[0].root = '0;
		sq_d[0].t0 = t0_s3;
		sq_d[0].t1 = t1_s3;
		sq_d[0].t2 = t2_s3;
		sq_d[0].t3 = t3_s3;
		sq_d[0].t4 = t4_s3;
	end

	for (genvar k = 0; k < qte_pkg::SQ_CELLS; k++) begin : g_sq
		qte_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (5'(qte_pkg::SQ_CELLS - 1 - k)),
			.in_valid  (sq_v[k]),
			.in_data   (sq_d[k]),
			.out_valid (sq_v[k+1]),
			.out_data  (sq_d[k+1])
		);
	end

	// CORDIC setup: zero flag and half-turn for negative x
	qte_pkg::sq_t       sq_o;
	logic signed [CW-1:0] ly [qte_pkg::LANES];
	logic signed [CW-1:0] lx [qte_pkg::LANES];
	qte_pkg::lanes_t    prep;
	qte_pkg::lanes_t    cd_d [qte_pkg::STEPS+1];
	logic               cd_v [qte_pkg::STEPS+1];

	assign sq_o = sq_d[qte_pkg::SQ_CELLS];

	always_comb begin
		ly[qte_pkg::LANE_ROLL] = CW'(sq_o.t3);
		lx[qte_pkg::LANE_ROLL] = CW'(sq_o.t4);
		ly[qte_pkg::LANE_PITCH] = CW'(sq_o.t2);
		lx[qte_pkg::LANE_PITCH] = CW'(signed'({1'b0, sq_o.root}));
		ly[qte_pkg::LANE_YAW] = CW'(sq_o.t1);
		lx[qte_pkg::LANE_YAW] = CW'(sq_o.t0);
		for (int l = 0; l < qte_pkg::LANES; l++) begin
			prep[l].zero = (lx[l] == '0) && (ly[l] == '0);
			if (lx[l][CW-1]) begin
				prep[l].x = -lx[l];
				prep[l].y = -ly[l];
				prep[l].z = ly[l][CW-1] ? -qte_pkg::PI_Q28 : qte_pkg::PI_Q28;
			end else begin
				prep[l].x = lx[l];
				prep[l].y = ly[l];
				prep[l].z = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_v[0] <= 1'b0;
		end else begin
			cd_v[0] <= sq_v[qte_pkg::SQ_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		cd_d[0] <= prep;
	end

	for (genvar i = 0; i < qte_pkg::STEPS; i++) begin : g_cd
		qte_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (5'(i)),
			.in_valid  (cd_v[i]),
			.in_data   (cd_d[i]),
			.out_valid (cd_v[i+1]),
			.out_data  (cd_d[i+1])
		);
	end

	// round 28 -> 13 fraction bits, clamp to range
	logic signed [ZW-1:0] rz [qte_pkg::LANES];
	logic signed [17:0]   ra [qte_pkg::LANES];
	logic signed [17:0]   lim [qte_pkg::LANES];
	logic signed [17:0]   rc [qte_pkg::LANES];

	always_comb begin
		lim[qte_pkg::LANE_ROLL] = 18'(qte_pkg::ANG_MAX);
		lim[qte_pkg::LANE_PITCH] = 18'(qte_pkg::PITCH_MAX);
		lim[qte_pkg::LANE_YAW] = 18'(qte_pkg::ANG_MAX);
		for (int l = 0; l < qte_pkg::LANES; l++) begin
			rz[l] = cd_d[qte_pkg::STEPS][l].z + ZW'(64'sd16384);
			ra[l] = cd_d[qte_pkg::STEPS][l].zero ? '0 : rz[l][ZW-1:15];
			if (ra[l] > lim[l]) begin
				rc[l] = lim[l];
			end else if (ra[l] < -lim[l]) begin
				rc[l] = -lim[l];
			end else begin
				rc[l] = ra[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cd_v[qte_pkg::STEPS];
		end
	end

	always_ff @(posedge clk) begin
		roll <= rc[qte_pkg::LANE_ROLL][15:0];
		pitch <= rc[qte_pkg::LANE_PITCH][14:0];
		yaw <= rc[qte_pkg::LANE_YAW][15:0];
	end

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("result missing after pipeline latency");
	a_pitch_rng : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch <= 15'(qte_pkg::PITCH_MAX) && pitch >= -15'(qte_pkg::PITCH_MAX)))
		else $error("pitch out of range");
	a_roll_rng : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (roll <= 16'(qte_pkg::ANG_MAX) && roll >= -16'(qte_pkg::ANG_MAX)))
		else $error("roll out of range");

endmodule
